// ===== sv/sols_pkg.sv =====
// Shared constants, codes and types of the self-organizing list search core.
package sols_pkg;

	localparam int DEPTH = 16;
	localparam int VAL_W = 32;
	localparam int CMD_W = 2;
	localparam int POL_W = 2;
	localparam int POS_W = 4;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [POL_W-1:0] {
		POL_PLAIN = 2'd0,
		POL_MTF   = 2'd1,
		POL_SWAP  = 2'd2
	} policy_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic             upd;
		logic [CMD_W-1:0] cmd;
		logic [POL_W-1:0] policy;
	} cell_ctrl_t;

endpackage

// ===== sv/sols_if.sv =====
// Request and response channel interfaces of the self-organizing list search core.
interface sols_req_if;
	import sols_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        command;
	logic signed [VAL_W-1:0] value;

	modport source(output valid, command, value, input ready);
	modport sink(input valid, command, value, output ready);
endinterface

interface sols_rsp_if;
	import sols_pkg::*;

	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] position;
	logic             rejected;

	modport source(output valid, found, position, rejected, input ready);
	modport sink(input valid, found, position, rejected, output ready);
endinterface

// ===== sv/sols_cell.sv =====
// One list slot: holds an entry, compares it with the key and shifts with its neighbors.
module sols_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       front,
	input  logic [sols_pkg::VAL_W-1:0] key,
	input  sols_pkg::cell_ctrl_t       ctrl,
	input  logic [sols_pkg::VAL_W-1:0] left_entry,
	input  logic                       left_valid,
	input  logic                       left_seen,
	input  logic                       right_first,
	input  logic                       right_tail,
	output logic [sols_pkg::VAL_W-1:0] entry,
	output logic                       valid,
	output logic                       seen,
	output logic                       first,
	output logic                       tail
);
	import sols_pkg::*;

	logic [VAL_W-1:0] entry_q;
	logic             valid_q;
	logic             match_q;
	logic             slot_free;

	// first hit from the front; tail means the first hit sits here or further back
	assign first     = match_q & ~left_seen;
	assign seen      = left_seen | match_q;
	assign tail      = right_tail | first;
	assign slot_free = ~valid_q & (front | left_valid);

	assign entry = entry_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			// drop the match together with the entry when the list is cleared
			match_q <= valid_q && (entry_q == key) && !(ctrl.upd && ctrl.cmd == CMD_CLEAR);
			if (ctrl.upd) begin
				case (ctrl.cmd)
					CMD_APPEND: if (slot_free) valid_q <= 1'b1;
					CMD_CLEAR:  valid_q <= 1'b0;
					default:    ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.upd) begin
			case (ctrl.cmd)
				CMD_APPEND: if (slot_free) entry_q <= key;
				CMD_SEARCH: begin
					case (ctrl.policy)
						POL_MTF: begin
							if (front) begin
								if (right_tail) entry_q <= key;
							end else if (first || right_tail) begin
								entry_q <= left_entry;
							end
						end
						POL_SWAP: begin
							if (!front && first) entry_q <= left_entry;
							else if (right_first) entry_q <= key;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/sols_ctrl.sv =====
// Sequencer, entry count, policy register, hit encoder and result register.
module sols_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	sols_req_if.sink                   req,
	sols_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [sols_pkg::POL_W-1:0] cfg_data,
	input  logic [sols_pkg::DEPTH-1:0] first_vec,
	output sols_pkg::cell_ctrl_t       ctrl,
	output logic [sols_pkg::VAL_W-1:0] key,
	output logic [sols_pkg::CNT_W-1:0] count
);
	import sols_pkg::*;

	state_t           state_q, state_nx;
	logic [CMD_W-1:0] cmd_q;
	logic [VAL_W-1:0] key_q;
	logic [POL_W-1:0] policy_q;
	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	logic             found_q;
	logic [POS_W-1:0] position_q;
	logic             rejected_q;

	logic             commit;
	logic             accept;
	logic             full;
	logic             hit;
	logic [POS_W-1:0] hit_pos;
	logic             res_found;
	logic [POS_W-1:0] res_pos;
	logic             res_rej;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign commit = (state_q == ST_UPD) && (!out_valid_q || rsp.ready);
	assign accept = req.valid && req.ready;

	assign ctrl.upd    = commit;
	assign ctrl.cmd    = cmd_q;
	assign ctrl.policy = policy_q;
	assign key         = key_q;
	assign count       = count_q;

	assign rsp.valid    = out_valid_q;
	assign rsp.found    = found_q;
	assign rsp.position = position_q;
	assign rsp.rejected = rejected_q;

	always_comb begin
		hit     = |first_vec;
		hit_pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first_vec[i]) hit_pos = hit_pos | POS_W'(i);
		end
	end

	always_comb begin
		res_found = 1'b0;
		res_pos   = '0;
		res_rej   = 1'b0;
		case (cmd_q)
			CMD_APPEND: begin
				res_rej = full;
				res_pos = full ? '0 : POS_W'(count_q);
			end
			CMD_SEARCH: begin
				res_found = hit;
				res_pos   = hit_pos;
			end
			default: ;
		endcase
	end

	// take the next item in the same cycle the current result is loaded
	always_comb begin
		state_nx  = state_q;
		req.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) state_nx = ST_CMP;
			end
			ST_CMP: state_nx = ST_UPD;
			ST_UPD: begin
				req.ready = commit;
				if (commit) state_nx = req.valid ? ST_CMP : ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= POL_PLAIN;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) policy_q <= cfg_data;
			if (commit) begin
				out_valid_q <= 1'b1;
				case (cmd_q)
					CMD_APPEND: if (!full) count_q <= count_q + CNT_W'(1);
					CMD_CLEAR:  count_q <= '0;
					default:    ;
				endcase
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.command;
			key_q <= req.value;
		end
		if (commit) begin
			found_q    <= res_found;
			position_q <= res_pos;
			rejected_q <= res_rej;
		end
	end

endmodule

// ===== sv/self_organizing_list_search_core.sv =====
// Top level of the self-organizing list search core: controller and the row of list cells.
// The list lives in a row of DEPTH cells, slot 0 at the front. An item is accepted, then in
// the next cycle every valid cell compares its entry with the key and registers the match;
// once the output register is free, a neighbor chain picks the first hit, every cell shifts
// or swaps with its neighbor as the policy asks (append fills the first free cell, clear
// drops all valid bits) and the result is loaded into the output register. An item passes
// the registered compare and then the reorder step; the next item is taken in the cycle its
// predecessor's result is loaded, so items do not overlap and wait while a result is held.
// Policy is to be written through cfg_we/cfg_data only while the core is idle; the core
// does not enforce it. Reset empties the list at once; entries hold no value until appended.
module self_organizing_list_search_core (
	input  logic                       clk,
	input  logic                       arst_n,
	sols_req_if.sink                   req,
	sols_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [sols_pkg::POL_W-1:0] cfg_data
);
	import sols_pkg::*;

	cell_ctrl_t       ctrl;
	logic [VAL_W-1:0] key;
	logic [CNT_W-1:0] count;

	logic [VAL_W-1:0] entry_vec [DEPTH];
	logic [DEPTH-1:0] valid_vec;
	logic [DEPTH-1:0] seen_vec;
	logic [DEPTH-1:0] first_vec;
	logic [DEPTH-1:0] tail_vec;

	sols_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.first_vec (first_vec),
		.ctrl      (ctrl),
		.key       (key),
		.count     (count)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] l_entry;
		logic             l_valid;
		logic             l_seen;
		logic             r_first;
		logic             r_tail;

		if (i == 0) begin : g_front
			assign l_entry = '0;
			assign l_valid = 1'b0;
			assign l_seen  = 1'b0;
		end else begin : g_mid
			assign l_entry = entry_vec[i-1];
			assign l_valid = valid_vec[i-1];
			assign l_seen  = seen_vec[i-1];
		end

		if (i == DEPTH - 1) begin : g_back
			assign r_first = 1'b0;
			assign r_tail  = 1'b0;
		end else begin : g_inner
			assign r_first = first_vec[i+1];
			assign r_tail  = tail_vec[i+1];
		end

		sols_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.front       (i == 0),
			.key         (key),
			.ctrl        (ctrl),
			.left_entry  (l_entry),
			.left_valid  (l_valid),
			.left_seen   (l_seen),
			.right_first (r_first),
			.right_tail  (r_tail),
			.entry       (entry_vec[i]),
			.valid       (valid_vec[i]),
			.seen        (seen_vec[i]),
			.first       (first_vec[i]),
			.tail        (tail_vec[i])
		);
	end

	// valid bits track the entry count and always form a prefix of the row
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count))
		else $error("valid cells disagree with entry count");

	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + DEPTH'(1))) == '0)
		else $error("valid cells are not a prefix of the list");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_vec))
		else $error("more than one cell claims the first hit");

	a_hit_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		((first_vec & ~valid_vec) == '0))
		else $error("hit reported in an empty cell");

endmodule
